// File: sv/tzm_pkg.sv
// tzm_pkg: widths, status codes and payload types for trapezoid_metrics.
// No dependencies.
package tzm_pkg;
	localparam int SW = 16;
	localparam int NW = 2 * SW + 1;            // numerator magnitude width
	localparam int DW = SW + 1;                // divisor 2*dmag width
	localparam int RW = SW;                    // sqrt result width
	localparam int HW = 2 * SW;                // sqrt radicand width
	localparam int DIV_STAGES = NW;
	localparam int SQ_STAGES = RW;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef struct packed {
		logic [SW-1:0] top_base;
		logic [SW-1:0] bottom_base;
		logic [SW-1:0] left_side;
		logic [SW-1:0] right_side;
	} tzm_in_t;

	typedef struct packed {
		logic [SW+1:0] perimeter;
		logic [SW-1:0] mid_line;
		logic [2*SW-1:0] area;
		logic [1:0] status;
	} tzm_out_t;
endpackage

// File: sv/tzm_if.sv
// tzm_if: valid/ready channels for the input and result payloads.
// Depends on tzm_pkg.
interface tzm_in_if import tzm_pkg::*;;
	logic valid;
	logic ready;
	tzm_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tzm_out_if import tzm_pkg::*;;
	logic valid;
	logic ready;
	tzm_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/trapezoid_metrics.sv
// trapezoid_metrics: perimeter, midline and area from four sides.
// Depends on tzm_pkg and tzm_if.
// Stages: 3 + 33 (divider, one quotient bit per stage) + 1 + 16 (sqrt, one bit
// per stage) + 2 between accept and valid output.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Reset clears all valid bits; payload registers are not reset.
module trapezoid_metrics import tzm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tzm_in_if.sink   in_ch,
	tzm_out_if.source out_ch
);
	localparam int NST = 3 + DIV_STAGES + 1 + SQ_STAGES + 2;

	typedef struct packed {
		logic [SW:0]     bases;
		logic [SW+1:0]   per;
		logic [SW-1:0]   left;
		logic [1:0]      status;
	} side_t;

	logic adv;
	logic [NST-1:0] vld_q;
	assign adv = !vld_q[NST-1] || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 1: sums, dmag, checks
	side_t sd_s1;
	logic [SW-1:0] dmag_s1, r_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.bases <= {1'b0, in_ch.data.top_base} + {1'b0, in_ch.data.bottom_base};
			sd_s1.per <= {2'b0, in_ch.data.top_base} + {2'b0, in_ch.data.bottom_base}
				+ {2'b0, in_ch.data.left_side} + {2'b0, in_ch.data.right_side};
			sd_s1.left <= in_ch.data.left_side;
			sd_s1.status <= (in_ch.data.top_base == '0 || in_ch.data.bottom_base == '0
				|| in_ch.data.left_side == '0 || in_ch.data.right_side == '0
				|| in_ch.data.top_base == in_ch.data.bottom_base) ? ST_ZERO : ST_OK;
			dmag_s1 <= (in_ch.data.bottom_base > in_ch.data.top_base)
				? in_ch.data.bottom_base - in_ch.data.top_base
				: in_ch.data.top_base - in_ch.data.bottom_base;
			r_s1 <= in_ch.data.right_side;
		end
	end

	// stage 2: squares
	side_t sd_s2;
	logic [SW-1:0] dmag_s2;
	logic [2*SW-1:0] d2_s2, l2_s2, r2_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2 <= sd_s1;
			dmag_s2 <= dmag_s1;
			d2_s2 <= dmag_s1 * dmag_s1;
			l2_s2 <= sd_s1.left * sd_s1.left;
			r2_s2 <= r_s1 * r_s1;
		end
	end

	// stage 3: numerator magnitude
	side_t sd_s3;
	logic [DW-1:0] div_s3;
	logic [NW-1:0] num_s3;
	logic [2*SW-1:0] l2_s3;
	logic [NW-1:0] pos;
	assign pos = {1'b0, d2_s2} + {1'b0, l2_s2};
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s3 <= sd_s2;
			l2_s3 <= l2_s2;
			div_s3 <= {dmag_s2, 1'b0};
			num_s3 <= (pos >= {1'b0, r2_s2}) ? pos - {1'b0, r2_s2} : {1'b0, r2_s2} - pos;
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	side_t sd_d [DIV_STAGES];
	logic [2*SW-1:0] l2_d [DIV_STAGES];
	logic [DW-1:0] dv_d [DIV_STAGES];
	logic [NW-1:0] nm_d [DIV_STAGES];
	logic [NW-1:0] rm_d [DIV_STAGES];
	logic [NW-1:0] qt_d [DIV_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				logic [NW-1:0] rin, rsh, nin, qin;
				side_t sin;
				logic [2*SW-1:0] lin;
				logic [DW-1:0] din;
				if (i == 0) begin
					rin = '0; nin = num_s3; qin = '0;
					sin = sd_s3; lin = l2_s3; din = div_s3;
				end else begin
					rin = rm_d[i-1]; nin = nm_d[i-1]; qin = qt_d[i-1];
					sin = sd_d[i-1]; lin = l2_d[i-1]; din = dv_d[i-1];
				end
				rsh = {rin[NW-2:0], nin[NW-1]};
				if (rsh >= {{(NW-DW){1'b0}}, din}) begin
					rm_d[i] <= rsh - {{(NW-DW){1'b0}}, din};
					qt_d[i] <= {qin[NW-2:0], 1'b1};
				end else begin
					rm_d[i] <= rsh;
					qt_d[i] <= {qin[NW-2:0], 1'b0};
				end
				nm_d[i] <= {nin[NW-2:0], 1'b0};
				sd_d[i] <= sin;
				l2_d[i] <= lin;
				dv_d[i] <= din;
			end
		end
	end

	// stage: range check and radicand (xmag <= left < 2^16 so square fits)
	side_t sd_r;
	logic [HW-1:0] rad_r;
	logic [NW-1:0] xq;
	logic [2*SW-1:0] xsq;
	assign xq = qt_d[DIV_STAGES-1];
	assign xsq = xq[SW-1:0] * xq[SW-1:0];
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_r.bases <= sd_d[DIV_STAGES-1].bases;
			sd_r.per <= sd_d[DIV_STAGES-1].per;
			sd_r.left <= sd_d[DIV_STAGES-1].left;
			sd_r.status <= (sd_d[DIV_STAGES-1].status == ST_OK
				&& xq > {{(NW-SW){1'b0}}, sd_d[DIV_STAGES-1].left})
				? ST_NONE : sd_d[DIV_STAGES-1].status;
			rad_r <= l2_d[DIV_STAGES-1] - xsq;
		end
	end

	// sqrt, one result bit per stage
	side_t sd_q [SQ_STAGES];
	logic [HW-1:0] rd_q [SQ_STAGES];
	logic [RW-1:0] rt_q [SQ_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SQ_STAGES; i++) begin
				logic [HW-1:0] rin, trial;
				logic [RW-1:0] tin, cand;
				side_t sin;
				if (i == 0) begin
					rin = rad_r; tin = '0; sin = sd_r;
				end else begin
					rin = rd_q[i-1]; tin = rt_q[i-1]; sin = sd_q[i-1];
				end
				cand = tin | (RW'(1) << (RW-1-i));
				trial = {{(HW-RW){1'b0}}, cand} * {{(HW-RW){1'b0}}, cand};
				rt_q[i] <= (trial <= rin) ? cand : tin;
				rd_q[i] <= rin;
				sd_q[i] <= sin;
			end
		end
	end

	// product and output
	side_t sd_p_s1;
	logic [2*SW:0] prod_s1;
	tzm_out_t out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_p_s1 <= sd_q[SQ_STAGES-1];
			prod_s1 <= sd_q[SQ_STAGES-1].bases * rt_q[SQ_STAGES-1];
			out_q.perimeter <= sd_p_s1.per;
			out_q.mid_line <= sd_p_s1.bases[SW:1];
			out_q.status <= sd_p_s1.status;
			out_q.area <= (sd_p_s1.status == ST_OK) ? prod_s1[2*SW:1] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_ch.valid};
		end
	end

	assign out_ch.valid = vld_q[NST-1];
	assign out_ch.data = out_q;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output changed under stall");
	a_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status != ST_OK |-> out_ch.data.area == '0)
		else $error("area nonzero with bad status");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("ready low with empty output");
`endif
endmodule
